// ===== rtl/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// shared widths, codes and control types of the insertable list engine
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int DEPTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KIND_W = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int OCNT_W = 6;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int S_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STAT_W + OCNT_W + VAL_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_INSERT     = 3'd2,
        KIND_REMOVE_AT  = 3'd3,
        KIND_POP_FRONT  = 3'd4,
        KIND_POP_BACK   = 3'd5,
        KIND_CLEAR      = 3'd6,
        KIND_DUMP       = 3'd7
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        STATE_IDLE = 1'b0,
        STATE_SEND = 1'b1
    } state_t;

    typedef struct packed {
        logic exec;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
    } dp_stat_t;

endpackage

// ===== rtl/ile_ctrl.sv =====
// ----------------------------------------------------------------------------
// ile_ctrl
// controller: takes one request, then hands out its results until the last
// ----------------------------------------------------------------------------
module ile_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  ile_pkg::dp_stat_t  dp_stat,
    output ile_pkg::ctrl_cmd_t cmd
);
    import ile_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            STATE_IDLE: begin
                if (s_tvalid) begin
                    state_next = STATE_SEND;
                end
            end
            STATE_SEND: begin
                if (m_tready && dp_stat.last) begin
                    state_next = STATE_IDLE;
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            STATE_IDLE: begin
                s_tready = 1'b1;
                cmd.exec = s_tvalid;
            end
            STATE_SEND: begin
                m_tvalid    = 1'b1;
                cmd.advance = m_tready && !dp_stat.last;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/ile_datapath.sv =====
// ----------------------------------------------------------------------------
// ile_datapath
// shifting cell chain, entry count, status decision and result registers
// ----------------------------------------------------------------------------
module ile_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ile_pkg::ctrl_cmd_t                  cmd,
    output ile_pkg::dp_stat_t                   dp_stat,
    input  ile_pkg::kind_t                      kind,
    input  logic [ile_pkg::POS_W-1:0]           position,
    input  logic signed [ile_pkg::VAL_W-1:0]    item_value,
    output ile_pkg::status_t                    status,
    output logic [ile_pkg::OCNT_W-1:0]          count,
    output logic signed [ile_pkg::VAL_W-1:0]    element,
    output logic                                last
);
    import ile_pkg::*;

    logic signed [VAL_W-1:0] cell_reg  [DEPTH];
    logic signed [VAL_W-1:0] cell_next [DEPTH];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_inc;
    status_t                 status_reg;
    status_t                 status_next;
    logic signed [VAL_W-1:0] element_reg;
    logic                    last_reg;

    logic             full;
    logic             ins_en;
    logic             rem_en;
    logic [CMP_W-1:0] op_idx;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;

    assign full    = (count_reg >= CNT_W'(DEPTH));
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    assign idx_inc = idx_reg + IDX_W'(1);

    // operation decode and status
    always_comb begin
        ins_en      = 1'b0;
        rem_en      = 1'b0;
        op_idx      = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        case (kind)
            KIND_PUSH_BACK: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    ins_en     = 1'b1;
                    op_idx     = cnt_ext;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_PUSH_FRONT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    ins_en     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    status_next = ST_BAD_INDEX;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    ins_en     = 1'b1;
                    op_idx     = pos_ext;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_REMOVE_AT: begin
                if (pos_ext >= cnt_ext) begin
                    status_next = ST_BAD_INDEX;
                end else begin
                    rem_en     = 1'b1;
                    op_idx     = pos_ext;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            KIND_POP_FRONT: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    rem_en     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            KIND_POP_BACK: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            KIND_CLEAR: begin
                count_next = '0;
            end
            KIND_DUMP: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // each cell takes from its neighbour, the new word or itself
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_next[i] = cell_reg[i];
        end
        if (ins_en) begin
            for (int i = 1; i < DEPTH; i++) begin
                if (CMP_W'(i) > op_idx) begin
                    cell_next[i] = cell_reg[i-1];
                end
            end
            for (int i = 0; i < DEPTH; i++) begin
                if (CMP_W'(i) == op_idx) begin
                    cell_next[i] = item_value;
                end
            end
        end
        if (rem_en) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (CMP_W'(i) >= op_idx) begin
                    cell_next[i] = cell_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            idx_reg    <= '0;
            if (kind == KIND_DUMP && count_reg != '0) begin
                element_reg <= cell_reg[0];
                last_reg    <= (count_reg == CNT_W'(1));
            end else begin
                element_reg <= '0;
                last_reg    <= 1'b1;
            end
        end else if (cmd.advance) begin
            idx_reg     <= idx_inc;
            element_reg <= cell_reg[idx_inc];
            last_reg    <= ((CNT_W'(idx_reg) + CNT_W'(2)) == count_reg);
        end
    end

    assign dp_stat.last = last_reg;
    assign status       = status_reg;
    assign count        = OCNT_W'(count_reg);
    assign element      = element_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/insertable_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// insertable_list_engine_unit
// ordered list of signed words with push, pop, insert, remove, clear and dump
// ----------------------------------------------------------------------------
// Each request names one operation on a list of up to DEPTH words held in a
// chain of cells that shift by one place when a request executes. A request
// is taken and its result is shown from the next cycle; a new request is taken
// in the cycle after the last result has been taken, as the controller
// alternates between taking a request and handing out results.
// Dump results come one per cycle while m_tready stays high. No clearing pass
// is needed after reset.
module insertable_list_engine_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ile_pkg::S_TDATA_W-1:0]     s_tdata,  // position, item_value
    input  logic [ile_pkg::KIND_W-1:0]        s_tuser,  // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ile_pkg::M_TDATA_W-1:0]     m_tdata,  // status, count, element
    output logic                              m_tlast
);
    import ile_pkg::*;

    ctrl_cmd_t               cmd;
    dp_stat_t                dp_stat;
    kind_t                   in_kind;
    logic [POS_W-1:0]        in_position;
    logic signed [VAL_W-1:0] in_value;
    status_t                 out_status;
    logic [OCNT_W-1:0]       out_count;
    logic signed [VAL_W-1:0] out_element;

    assign in_kind     = kind_t'(s_tuser);
    assign in_position = s_tdata[POS_W-1:0];
    assign in_value    = s_tdata[POS_W+VAL_W-1:POS_W];

    ile_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    ile_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .dp_stat    (dp_stat),
        .kind       (in_kind),
        .position   (in_position),
        .item_value (in_value),
        .status     (out_status),
        .count      (out_count),
        .element    (out_element),
        .last       (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({out_element, out_count, out_status});

endmodule

// ===== rtl/ile_checker.sv =====
// ----------------------------------------------------------------------------
// ile_checker
// port-level checks of the insertable list engine, bound to the top level
// ----------------------------------------------------------------------------
module ile_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ile_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import ile_pkg::*;

    logic [STAT_W-1:0] chk_status;
    logic [OCNT_W-1:0] chk_count;
    logic [VAL_W-1:0]  chk_element;

    assign chk_status  = m_tdata[STAT_W-1:0];
    assign chk_count   = m_tdata[STAT_W+OCNT_W-1:STAT_W];
    assign chk_element = m_tdata[STAT_W+OCNT_W+VAL_W-1:STAT_W+OCNT_W];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // no new request while results are pending
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request taken while results pending");

    // a dump run continues until its last entry
    a_dump_runs_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && !s_tready)
        else $error("dump run broken off");

    // empty result is a single zero item
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_status == ST_EMPTY |-> m_tlast && chk_count == '0
        && chk_element == '0)
        else $error("bad empty result");

    // full status only with the list at capacity
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_status == ST_FULL |-> chk_count == OCNT_W'(DEPTH) && m_tlast)
        else $error("full status with wrong count");

endmodule

bind insertable_list_engine_unit ile_checker u_ile_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
